// ===== rtl/btm_pkg.sv =====
// ----------------------------------------------------------------------------
// btm_pkg
// shared types and constants for the binary trie multiset
// ----------------------------------------------------------------------------
package btm_pkg;

  localparam int VALUE_BITS = 32;
  localparam int POOL_NODES = 65536;
  localparam int COUNT_BITS = 32;
  localparam int NODE_BITS  = $clog2(POOL_NODES);
  localparam int LVL_BITS   = $clog2(VALUE_BITS + 1);
  localparam int IDX_BITS   = $clog2(VALUE_BITS);
  localparam int QDEPTH     = 2;

  typedef logic [NODE_BITS-1:0]  node_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [LVL_BITS-1:0]   lvl_t;
  typedef logic [IDX_BITS-1:0]   bidx_t;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_FREQ   = 3'd2,
    OP_CNTLT  = 3'd3,
    OP_KTH    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OVER_REM = 3'd1,
    ST_RANK     = 3'd2,
    ST_POOL     = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  // classified work item handed from front to back
  typedef struct packed {
    logic [2:0]            opcode;
    logic                  nop;
    logic [VALUE_BITS-1:0] value;
    logic [31:0]           amount;
    logic [VALUE_BITS-1:0] xor_mask;
  } work_t;

endpackage

// ===== rtl/btm_if.sv =====
// ----------------------------------------------------------------------------
// btm_in_if / btm_out_if
// valid/ready channels for items and results
// ----------------------------------------------------------------------------
interface btm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] value;
  logic [31:0] amount;
  logic [31:0] xor_mask;
  modport source (output valid, opcode, value, amount, xor_mask, input ready);
  modport sink   (input valid, opcode, value, amount, xor_mask, output ready);
endinterface

interface btm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic [31:0] result_count;
  logic [31:0] total_stored;
  logic [2:0]  status;
  modport source (output valid, result_value, result_count, total_stored, status,
                  input ready);
  modport sink   (input valid, result_value, result_count, total_stored, status,
                  output ready);
endinterface

// ===== rtl/btm_front.sv =====
// ----------------------------------------------------------------------------
// btm_front
// accepts item beats, classifies them and queues work for the back end
// ----------------------------------------------------------------------------
module btm_front
  import btm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  btm_in_if.sink     in_ch,
  output logic       q_valid,
  input  logic       q_pop,
  output work_t      q_head
);

  work_t                    q_mem_r [QDEPTH];
  logic [$clog2(QDEPTH):0]  cnt_r, cnt_nxt;
  logic [$clog2(QDEPTH)-1:0] rd_r, wr_r;
  logic                     push;
  work_t                    w;

  always_comb begin
    w.opcode   = in_ch.opcode;
    w.value    = in_ch.value[VALUE_BITS-1:0];
    w.amount   = in_ch.amount;
    w.xor_mask = in_ch.xor_mask[VALUE_BITS-1:0];
    w.nop      = (in_ch.opcode > OP_KTH) ||
                 ((in_ch.opcode == OP_INSERT || in_ch.opcode == OP_REMOVE) &&
                  in_ch.amount == '0);
  end

  assign in_ch.ready = (cnt_r != ($clog2(QDEPTH)+1)'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign q_head      = q_mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + ($clog2(QDEPTH)+1)'(push) - ($clog2(QDEPTH)+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= '0;
      wr_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= wr_r + 1'b1;
      if (q_pop) rd_r <= rd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_r] <= w;
  end

endmodule

// ===== rtl/btm_back.sv =====
// ----------------------------------------------------------------------------
// btm_back
// walks the trie node pool one level at a time and drives results
// ----------------------------------------------------------------------------
module btm_back
  import btm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  output logic    q_pop,
  input  work_t   q_head,
  btm_out_if.source out_ch
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,
    S_WAIT  = 7'b0000100,
    S_STEP  = 7'b0001000,
    S_TRD   = 7'b0010000,
    S_TSTEP = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  // walk phases
  typedef enum logic [2:0] {
    PH_PROBE = 3'b001,
    PH_APPLY = 3'b010,
    PH_QUERY = 3'b100
  } phase_t;

  node_t left_mem  [POOL_NODES];
  node_t right_mem [POOL_NODES];
  cnt_t  tally_mem [POOL_NODES];

  state_t  st_r;
  phase_t  ph_r;
  work_t   wk_r;
  node_t   u_r;
  lvl_t    lvl_r;
  logic [NODE_BITS:0] free_r;
  cnt_t    root_r;
  cnt_t    k_r, acc_r;
  logic [VALUE_BITS-1:0] rv_r;

  node_t rd_l_r, rd_r_r;
  cnt_t  rd_t_r;
  node_t t_addr;
  cnt_t  rdt2_r;

  logic  mem_we;
  node_t we_addr;
  node_t we_l, we_r;
  cnt_t  we_t;
  logic  link_we, link_side;
  node_t link_addr, link_val;

  logic [31:0] o_val_r, o_cnt_r;
  logic [2:0]  o_st_r;
  logic        o_vld_r;

  logic        bit_v, bit_m, dir;
  node_t       child;
  logic        lvl_last;
  cnt_t        walk_tally;
  bidx_t       bidx;

  assign bidx     = bidx_t'(lvl_r - 1'b1);
  assign bit_v    = wk_r.value[bidx];
  assign bit_m    = wk_r.xor_mask[bidx];
  assign lvl_last = (lvl_r == '0);
  assign walk_tally = (u_r == '0) ? root_r : rd_t_r;

  always_comb begin
    dir = bit_v;
    if (wk_r.opcode == OP_CNTLT) dir = bit_m ^ bit_v;
    else if (wk_r.opcode == OP_KTH) dir = bit_m;
    child = dir ? rd_r_r : rd_l_r;
  end

  // node memory ports
  always_ff @(posedge clk) begin
    rd_l_r <= left_mem[u_r];
    rd_r_r <= right_mem[u_r];
    rd_t_r <= tally_mem[u_r];
    rdt2_r <= tally_mem[t_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tally_mem[we_addr] <= we_t;
    end
  end

  // root links are cleared while reset is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_mem[0]  <= '0;
      right_mem[0] <= '0;
    end else if (mem_we && !link_we) begin
      left_mem[we_addr]  <= we_l;
      right_mem[we_addr] <= we_r;
    end else if (link_we && !link_side) begin
      left_mem[link_addr] <= link_val;
    end else if (link_we && link_side) begin
      right_mem[link_addr] <= link_val;
    end
  end

  assign t_addr = (wk_r.opcode == OP_CNTLT) ? (bit_m ? rd_r_r : rd_l_r)
                                            : (bit_m ? rd_r_r : rd_l_r);

  assign out_ch.valid        = o_vld_r;
  assign out_ch.result_value = o_val_r;
  assign out_ch.result_count = o_cnt_r;
  assign out_ch.total_stored = root_r;
  assign out_ch.status       = o_st_r;

  assign q_pop = (st_r == S_IDLE) && q_valid && !o_vld_r;

  always_comb begin
    mem_we    = 1'b0;
    we_addr   = u_r;
    we_l      = rd_l_r;
    we_r      = rd_r_r;
    we_t      = rd_t_r;
    link_we   = 1'b0;
    link_side = dir;
    link_addr = u_r;
    link_val  = free_r[NODE_BITS-1:0];
    if (st_r == S_STEP && ph_r == PH_APPLY && u_r != '0) begin
      mem_we = 1'b1;
      we_t   = (wk_r.opcode == OP_INSERT) ? rd_t_r + wk_r.amount
                                          : rd_t_r - wk_r.amount;
    end
    if (st_r == S_STEP && ph_r == PH_APPLY && wk_r.opcode == OP_INSERT &&
        !lvl_last && child == '0) begin
      link_we = 1'b1;
    end
    if (st_r == S_TSTEP && ph_r == PH_APPLY) begin
      mem_we  = 1'b1;
      we_addr = free_r[NODE_BITS-1:0];
      we_l    = '0;
      we_r    = '0;
      we_t    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      ph_r    <= PH_QUERY;
      o_vld_r <= 1'b0;
      free_r  <= (NODE_BITS+1)'(1);
      root_r  <= '0;
      u_r     <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) o_vld_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (q_pop) begin
            wk_r  <= q_head;
            u_r   <= '0;
            lvl_r <= lvl_t'(VALUE_BITS);
            acc_r <= '0;
            rv_r  <= '0;
            k_r   <= q_head.amount;
            o_val_r <= '0;
            o_cnt_r <= '0;
            o_st_r  <= ST_OK;
            if (q_head.nop) begin
              st_r <= S_DONE;
            end else if (q_head.opcode == OP_INSERT) begin
              if ({1'b0, q_head.amount} > {1'b0, {COUNT_BITS{1'b1}}} - {1'b0, root_r}) begin
                o_st_r <= ST_OVERFLOW;
                st_r   <= S_DONE;
              end else begin
                ph_r   <= PH_PROBE;
                st_r   <= S_RD;
              end
            end else if (q_head.opcode == OP_REMOVE) begin
              ph_r <= PH_PROBE;
              st_r <= S_RD;
            end else if (q_head.opcode == OP_KTH && q_head.amount >= root_r) begin
              o_st_r <= ST_RANK;
              st_r   <= S_DONE;
            end else begin
              ph_r <= PH_QUERY;
              st_r <= S_RD;
            end
          end
        end
        S_RD:   st_r <= S_WAIT;
        S_WAIT: st_r <= S_STEP;
        S_STEP: begin
          if (ph_r == PH_PROBE) begin
            if (lvl_last || child == '0) begin
              if (wk_r.opcode == OP_INSERT) begin
                if ((NODE_BITS+1)'(POOL_NODES) - free_r < (NODE_BITS+1)'(lvl_r)) begin
                  o_st_r <= ST_POOL;
                  st_r   <= S_DONE;
                end else begin
                  ph_r <= PH_APPLY;
                  u_r  <= '0;
                  lvl_r <= lvl_t'(VALUE_BITS);
                  st_r <= S_RD;
                end
              end else if (!lvl_last || rd_t_r < wk_r.amount) begin
                o_st_r <= ST_OVER_REM;
                st_r   <= S_DONE;
              end else begin
                ph_r  <= PH_APPLY;
                u_r   <= '0;
                lvl_r <= lvl_t'(VALUE_BITS);
                st_r  <= S_RD;
              end
            end else begin
              u_r   <= child;
              lvl_r <= lvl_r - 1'b1;
              st_r  <= S_RD;
            end
          end else if (ph_r == PH_APPLY) begin
            if (u_r == '0) begin
              root_r <= (wk_r.opcode == OP_INSERT) ? root_r + wk_r.amount
                                                   : root_r - wk_r.amount;
            end
            if (lvl_last) begin
              st_r <= S_DONE;
            end else if (wk_r.opcode == OP_INSERT && child == '0) begin
              st_r <= S_TSTEP;
            end else begin
              u_r   <= child;
              lvl_r <= lvl_r - 1'b1;
              st_r  <= S_RD;
            end
          end else begin
            // query walk
            if (wk_r.opcode == OP_FREQ) begin
              if (lvl_last) begin
                o_cnt_r <= (u_r == '0) ? root_r : rd_t_r;
                st_r    <= S_DONE;
              end else if (child == '0) begin
                st_r <= S_DONE;
              end else begin
                u_r   <= child;
                lvl_r <= lvl_r - 1'b1;
                st_r  <= S_RD;
              end
            end else if (lvl_last) begin
              if (wk_r.opcode == OP_KTH) begin
                o_val_r <= rv_r;
                o_cnt_r <= walk_tally;
              end else begin
                o_cnt_r <= acc_r;
              end
              st_r <= S_DONE;
            end else begin
              st_r <= S_TRD;
            end
          end
        end
        S_TRD: st_r <= S_TSTEP;
        S_TSTEP: begin
          if (ph_r == PH_APPLY) begin
            // fresh node written, link stored at S_STEP
            free_r <= free_r + 1'b1;
            u_r    <= free_r[NODE_BITS-1:0];
            lvl_r  <= lvl_r - 1'b1;
            st_r   <= S_RD;
          end else if (wk_r.opcode == OP_CNTLT) begin
            node_t nx;
            cnt_t  ad;
            nx = (bit_m ^ bit_v) ? rd_r_r : rd_l_r;
            ad = ((bit_m ? rd_r_r : rd_l_r) == '0) ? '0 : rdt2_r;
            if (bit_v) acc_r <= acc_r + ad;
            if (nx == '0) begin
              o_cnt_r <= bit_v ? acc_r + ad : acc_r;
              st_r    <= S_DONE;
            end else begin
              u_r   <= nx;
              lvl_r <= lvl_r - 1'b1;
              st_r  <= S_RD;
            end
          end else begin
            node_t nm, nb;
            cnt_t  t;
            logic  b;
            nm = bit_m ? rd_r_r : rd_l_r;
            t  = (nm == '0) ? '0 : rdt2_r;
            b  = bit_m;
            if (t <= k_r) begin
              k_r <= k_r - t;
              b   = ~bit_m;
            end
            nb = b ? rd_r_r : rd_l_r;
            rv_r[bidx] <= b;
            if (nb == '0) begin
              o_val_r <= rv_r | (VALUE_BITS'(b) << bidx);
              o_cnt_r <= '0;
              st_r    <= S_DONE;
            end else begin
              u_r   <= nb;
              lvl_r <= lvl_r - 1'b1;
              st_r  <= S_RD;
            end
          end
        end
        S_DONE: begin
          if (!o_vld_r || (out_ch.valid && out_ch.ready)) begin
            o_vld_r <= 1'b1;
            st_r    <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/binary_trie_multiset.sv =====
// binary trie multiset: one item in flight; the next starts once its result beat is taken
// frequency: each level passes through S_RD, S_WAIT and S_STEP
// count-below and k-th: each level passes through S_RD, S_WAIT, S_STEP, S_TRD and S_TSTEP
// insert/remove: probe walk then update walk, plus an S_TSTEP pass per new node
// a two-entry queue holds item beats while the walk engine is busy
// synchronous active-low reset empties the trie (root only, next free node 1)
// ----------------------------------------------------------------------------
// binary_trie_multiset
// top level: front queue plus trie walk back end
// ----------------------------------------------------------------------------
module binary_trie_multiset
  import btm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  btm_in_if.sink    in_ch,
  btm_out_if.source out_ch
);

  logic  q_valid, q_pop;
  work_t q_head;

  btm_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
  );

  btm_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
    .q_head(q_head), .out_ch(out_ch)
  );

  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.result_count))
    else $error("result dropped");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.status <= ST_OVERFLOW) else $error("bad status");

endmodule
